FILE: rtl/ptom_pkg.sv
package ptom_pkg;

    localparam int MAX_SAMPLES_DEF = 200;
    localparam int OFS_W           = 41;
    localparam int TIME_W          = 40;
    localparam int ADDR_W          = 128;
    localparam int CNT_OUT_W       = 8;
    localparam int MIN_WINDOW      = 5;
    localparam int NTP_LIMIT       = 40 * 60;
    localparam int NODES_LIMIT     = 70 * 60;
    localparam int NEAR_LIMIT      = 5 * 60;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DUP,
        S_STORE,
        S_RMV,
        S_INSS,
        S_INS,
        S_INS0,
        S_EVAL,
        S_EVW,
        S_NEAR,
        S_FIN
    } state_t;

endpackage

FILE: rtl/ptom_ram.sv
module ptom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/peer_time_offset_median.sv
// Peer time offset median filter.
//
// Input channel (in_valid / in_stall): one peer time report per transfer,
// a 128-bit address split in two halves, the peer time and the local time.
// Output channel (out_valid / out_stall): exactly one result per report.
// Configuration: cfg_we writes cfg_wdata into the NTP offset register; write
// it only while no report is in flight.
//
// One report is worked at a time. A report that finds the store full goes
// straight to the result; otherwise the duplicate search walks the address
// RAM, the sorted insertion walks the offset RAM from the top, a one-time
// zero removal when the window fills adds another walk, and a warning check
// may scan the whole window once more. Each walk moves one RAM entry per cycle
// through the single read port of the RAM involved.
//
// Reset clears the count, the median, the warning and the NTP offset; the
// window then holds only the node's own zero sample. A finished result sits
// in the output register while the next report is already taken; if the
// receiver keeps stalling, the following result waits in its final state.
module peer_time_offset_median #(
    parameter int MAX_SAMPLES = ptom_pkg::MAX_SAMPLES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic signed [ptom_pkg::OFS_W-1:0]   cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [63:0]                         addr_high,
    input  logic [63:0]                         addr_low,
    input  logic [ptom_pkg::TIME_W-1:0]         peer_time,
    input  logic [ptom_pkg::TIME_W-1:0]         local_time,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                accepted,
    output logic [ptom_pkg::CNT_OUT_W-1:0]      sample_count,
    output logic                                nodes_valid,
    output logic signed [ptom_pkg::OFS_W-1:0]   nodes_offset,
    output logic signed [ptom_pkg::OFS_W-1:0]   selected_offset,
    output logic                                clock_warning
);

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int OW = ptom_pkg::OFS_W;

    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SAMPLES);
    localparam logic [CW-1:0] WIN_MIN = CW'(ptom_pkg::MIN_WINDOW);
    localparam logic signed [OW-1:0] NTP_LIM   = OW'(ptom_pkg::NTP_LIMIT);
    localparam logic signed [OW-1:0] NODES_LIM = OW'(ptom_pkg::NODES_LIMIT);
    localparam logic signed [OW-1:0] NEAR_LIM  = OW'(ptom_pkg::NEAR_LIMIT);

    ptom_pkg::state_t st_reg, st_next;

    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          wl_reg, wl_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [AW-1:0]          pidx_reg, pidx_next;
    logic                   pv_reg, pv_next;
    logic                   more_reg, more_next;
    logic                   first_reg, first_next;
    logic                   w0_reg, w0_next;
    logic                   acc_reg, acc_next;
    logic                   mv_reg, mv_next;
    logic                   warned_reg, warned_next;
    logic signed [OW-1:0]   med_reg, med_next;
    logic signed [OW-1:0]   ntp_reg;
    logic signed [OW-1:0]   x_reg, x_next;
    logic signed [OW-1:0]   carry_reg, carry_next;
    logic [127:0]           key_reg, key_next;
    logic                   ovalid_reg, ovalid_next;

    logic                   o_acc_reg;
    logic [ptom_pkg::CNT_OUT_W-1:0] o_cnt_reg;
    logic                   o_nv_reg;
    logic signed [OW-1:0]   o_no_reg;
    logic signed [OW-1:0]   o_sel_reg;
    logic                   o_warn_reg;
    logic                   load;

    // RAM ports
    logic                   a_we;
    logic [AW-1:0]          a_waddr, a_raddr;
    logic [127:0]           a_rdata;
    logic                   s_we;
    logic [AW-1:0]          s_waddr, s_raddr;
    logic signed [OW-1:0]   s_wdata;
    logic [OW-1:0]          s_rdata;

    logic signed [OW-1:0]   sv;
    logic                   hit, gt, sv_zero, sv_near, sv_good;
    logic [CW-1:0]          top_idx;
    logic signed [OW-1:0]   sel;

    ptom_ram #(.WIDTH(128), .DEPTH(MAX_SAMPLES)) u_addr_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (key_reg),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    ptom_ram #(.WIDTH(OW), .DEPTH(MAX_SAMPLES)) u_ofs_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    // Entry 0 holds the node's own zero sample until first written.
    assign sv      = (pidx_reg == '0 && !w0_reg) ? '0 : $signed(s_rdata);
    assign hit     = (a_rdata == key_reg);
    assign gt      = (sv > x_reg);
    assign sv_zero = (sv == '0);
    assign sv_near = (sv > -NEAR_LIM) && (sv < NEAR_LIM);
    assign sv_good = (sv > -NODES_LIM) && (sv < NODES_LIM);
    assign top_idx = wl_reg - CW'(1);

    assign in_stall = (st_reg != ptom_pkg::S_IDLE);
    assign load     = (st_reg == ptom_pkg::S_FIN) && (!ovalid_reg || !out_stall);

    always_comb
    begin
        if ((ntp_reg > -NTP_LIM) && (ntp_reg < NTP_LIM))
        begin
            sel = ntp_reg;
        end
        else if (mv_reg)
        begin
            sel = med_reg;
        end
        else
        begin
            sel = '0;
        end
    end

    // RAM control
    always_comb
    begin
        a_we    = (st_reg == ptom_pkg::S_STORE);
        a_waddr = count_reg[AW-1:0];
        a_raddr = idx_reg[AW-1:0];
        s_raddr = idx_reg[AW-1:0];
        s_we    = 1'b0;
        s_waddr = pidx_reg;
        s_wdata = carry_reg;
        unique case (st_reg)
            ptom_pkg::S_RMV:
            begin
                // shift entries down over the removed zero
                s_we    = pv_reg && !first_reg;
                s_waddr = pidx_reg;
                s_wdata = carry_reg;
            end
            ptom_pkg::S_INS:
            begin
                s_we    = pv_reg;
                s_waddr = pidx_reg + AW'(1);
                s_wdata = gt ? sv : x_reg;
            end
            ptom_pkg::S_INS0:
            begin
                s_we    = 1'b1;
                s_waddr = '0;
                s_wdata = x_reg;
            end
            ptom_pkg::S_EVAL:
            begin
                s_raddr = AW'(wl_reg[CW-1:1]);
            end
            default:
            begin
            end
        endcase
    end

    // Next state and datapath
    always_comb
    begin
        st_next     = st_reg;
        count_next  = count_reg;
        wl_next     = wl_reg;
        idx_next    = idx_reg;
        pidx_next   = pidx_reg;
        pv_next     = 1'b0;
        more_next   = more_reg;
        first_next  = first_reg;
        w0_next     = w0_reg || (s_we && s_waddr == '0);
        acc_next    = acc_reg;
        mv_next     = mv_reg;
        warned_next = warned_reg;
        med_next    = med_reg;
        x_next      = x_reg;
        carry_next  = carry_reg;
        key_next    = key_reg;
        ovalid_next = ovalid_reg && out_stall;
        unique case (st_reg)
            ptom_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next = {addr_high, addr_low};
                    x_next   = $signed({1'b0, peer_time}) - $signed({1'b0, local_time});
                    acc_next = 1'b0;
                    idx_next = '0;
                    if (count_reg == CNT_MAX)
                    begin
                        st_next = ptom_pkg::S_FIN;
                    end
                    else if (count_reg == '0)
                    begin
                        st_next = ptom_pkg::S_STORE;
                    end
                    else
                    begin
                        st_next = ptom_pkg::S_DUP;
                    end
                end
            end
            ptom_pkg::S_DUP:
            begin
                if (idx_reg < count_reg)
                begin
                    pv_next   = 1'b1;
                    pidx_next = idx_reg[AW-1:0];
                    idx_next  = idx_reg + CW'(1);
                end
                if (pv_reg && hit)
                begin
                    st_next = ptom_pkg::S_FIN;
                end
                else if (!pv_reg && idx_reg >= count_reg)
                begin
                    st_next = ptom_pkg::S_STORE;
                end
            end
            ptom_pkg::S_STORE:
            begin
                count_next = count_reg + CW'(1);
                acc_next   = 1'b1;
                idx_next   = top_idx;
                more_next  = 1'b1;
                first_next = 1'b1;
                st_next    = (wl_reg == CNT_MAX) ? ptom_pkg::S_RMV : ptom_pkg::S_INSS;
            end
            ptom_pkg::S_RMV:
            begin
                if (more_reg)
                begin
                    pv_next   = 1'b1;
                    pidx_next = idx_reg[AW-1:0];
                    idx_next  = idx_reg - CW'(1);
                    more_next = (idx_reg != '0);
                end
                if (pv_reg)
                begin
                    first_next = 1'b0;
                    carry_next = sv;
                    if (sv_zero)
                    begin
                        wl_next = wl_reg - CW'(1);
                        pv_next = 1'b0;
                        st_next = ptom_pkg::S_INSS;
                    end
                end
            end
            ptom_pkg::S_INSS:
            begin
                idx_next  = top_idx;
                more_next = 1'b1;
                st_next   = ptom_pkg::S_INS;
            end
            ptom_pkg::S_INS:
            begin
                if (more_reg)
                begin
                    pv_next   = 1'b1;
                    pidx_next = idx_reg[AW-1:0];
                    idx_next  = idx_reg - CW'(1);
                    more_next = (idx_reg != '0);
                end
                if (pv_reg)
                begin
                    if (!gt)
                    begin
                        wl_next = wl_reg + CW'(1);
                        pv_next = 1'b0;
                        st_next = ptom_pkg::S_EVAL;
                    end
                    else if (pidx_reg == '0)
                    begin
                        pv_next = 1'b0;
                        st_next = ptom_pkg::S_INS0;
                    end
                end
            end
            ptom_pkg::S_INS0:
            begin
                wl_next = wl_reg + CW'(1);
                st_next = ptom_pkg::S_EVAL;
            end
            ptom_pkg::S_EVAL:
            begin
                pidx_next = AW'(wl_reg[CW-1:1]);
                if (wl_reg < WIN_MIN || !wl_reg[0])
                begin
                    st_next = ptom_pkg::S_FIN;
                end
                else
                begin
                    st_next = ptom_pkg::S_EVW;
                end
            end
            ptom_pkg::S_EVW:
            begin
                idx_next = '0;
                if (sv_good)
                begin
                    med_next = sv;
                    mv_next  = 1'b1;
                    st_next  = ptom_pkg::S_FIN;
                end
                else
                begin
                    med_next = '0;
                    mv_next  = 1'b0;
                    st_next  = warned_reg ? ptom_pkg::S_FIN : ptom_pkg::S_NEAR;
                end
            end
            ptom_pkg::S_NEAR:
            begin
                if (idx_reg < wl_reg)
                begin
                    pv_next   = 1'b1;
                    pidx_next = idx_reg[AW-1:0];
                    idx_next  = idx_reg + CW'(1);
                end
                if (pv_reg && !sv_zero && sv_near)
                begin
                    st_next = ptom_pkg::S_FIN;
                end
                else if (!pv_reg && idx_reg >= wl_reg)
                begin
                    warned_next = 1'b1;
                    st_next     = ptom_pkg::S_FIN;
                end
            end
            ptom_pkg::S_FIN:
            begin
                if (load)
                begin
                    ovalid_next = 1'b1;
                    st_next     = ptom_pkg::S_IDLE;
                end
            end
            default:
            begin
                st_next = ptom_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ptom_pkg::S_IDLE;
            count_reg  <= '0;
            wl_reg     <= CW'(1);
            idx_reg    <= '0;
            pv_reg     <= 1'b0;
            more_reg   <= 1'b0;
            first_reg  <= 1'b0;
            w0_reg     <= 1'b0;
            acc_reg    <= 1'b0;
            mv_reg     <= 1'b0;
            warned_reg <= 1'b0;
            med_reg    <= '0;
            ntp_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            count_reg  <= count_next;
            wl_reg     <= wl_next;
            idx_reg    <= idx_next;
            pv_reg     <= pv_next;
            more_reg   <= more_next;
            first_reg  <= first_next;
            w0_reg     <= w0_next;
            acc_reg    <= acc_next;
            mv_reg     <= mv_next;
            warned_reg <= warned_next;
            med_reg    <= med_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
            begin
                ntp_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pidx_reg  <= pidx_next;
        x_reg     <= x_next;
        carry_reg <= carry_next;
        key_reg   <= key_next;
        if (load)
        begin
            o_acc_reg  <= acc_reg;
            o_cnt_reg  <= ptom_pkg::CNT_OUT_W'(count_reg);
            o_nv_reg   <= mv_reg;
            o_no_reg   <= mv_reg ? med_reg : '0;
            o_sel_reg  <= sel;
            o_warn_reg <= warned_reg;
        end
    end

    assign out_valid       = ovalid_reg;
    assign accepted        = o_acc_reg;
    assign sample_count    = o_cnt_reg;
    assign nodes_valid     = o_nv_reg;
    assign nodes_offset    = o_no_reg;
    assign selected_offset = o_sel_reg;
    assign clock_warning   = o_warn_reg;

endmodule
